### hdl/btp_pkg.sv
// Shared types and constants of the bus turn poller.
`timescale 1ns / 1ps
`default_nettype none
package btp_pkg;

  // Input modes
  localparam logic [2:0] MODE_ASSIGN   = 3'd0;
  localparam logic [2:0] MODE_START    = 3'd1;
  localparam logic [2:0] MODE_PACKET   = 3'd2;
  localparam logic [2:0] MODE_TIMEOUT  = 3'd3;
  localparam logic [2:0] MODE_STOP     = 3'd4;
  localparam logic [2:0] MODE_UNASSIGN = 3'd5;

  // Received packet kinds
  localparam logic [1:0] PKT_TRANSMIT = 2'd0;
  localparam logic [1:0] PKT_SUCCESS  = 2'd1;
  localparam logic [1:0] PKT_FAIL     = 2'd2;
  localparam logic [1:0] PKT_OTHER    = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_TURN        = 3'd0;
  localparam logic [2:0] KIND_SUCCESS     = 3'd1;
  localparam logic [2:0] KIND_END_TX      = 3'd2;
  localparam logic [2:0] KIND_QUIT_ANN    = 3'd3;
  localparam logic [2:0] KIND_DELIVER     = 3'd4;
  localparam logic [2:0] KIND_MEMBER_QUIT = 3'd5;
  localparam logic [2:0] KIND_CYCLE_DONE  = 3'd6;
  localparam logic [2:0] KIND_WAIT        = 3'd7;

  // Configuration register indexes
  localparam logic REG_TOPICS_LOW  = 1'b0;
  localparam logic REG_TOPICS_HIGH = 1'b1;

  // Channel map geometry: 256 channels as 32 rows of 8 bits
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned ROWS     = 32;
  localparam logic [4:0]  LAST_ROW = 5'd31;
  localparam logic [7:0]  LAST_CHANNEL = 8'd255;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] channel;
    logic [1:0] packet_kind;
    logic [7:0] target;
    logic [7:0] source;
  } btp_in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       arm_timeout;
    logic       last;
  } btp_out_t;

  typedef struct packed {
    logic             rd;
    logic             wr;
    logic [ROW_W-1:0] row;
    logic [7:0]       wdata;
  } btp_map_req_t;

endpackage
`default_nettype wire

### hdl/btp_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
`timescale 1ns / 1ps
`default_nettype none
interface btp_stream_if #(
  parameter type T = logic [7:0]
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/btp_map.sv
// Channel assignment map: 32 x 8 synchronous memory with per-row valid bits.
`timescale 1ns / 1ps
`default_nettype none
module btp_map
  import btp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire btp_map_req_t req,
  output logic [7:0]        rdata
);

  logic [7:0]       mem [ROWS];
  logic [ROWS-1:0]  rowv_r;
  logic [ROW_W-1:0] rd_row_r;
  logic [7:0]       q_r;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.row] <= req.wdata;
    end
    if (req.rd) begin
      q_r      <= mem[req.row];
      rd_row_r <= req.row;
    end
  end

  // Rows never written read as clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rowv_r <= '0;
    end else if (req.wr) begin
      rowv_r[req.row] <= 1'b1;
    end
  end

  assign rdata = rowv_r[rd_row_r] ? q_r : 8'h00;

endmodule
`default_nettype wire

### hdl/bus_turn_poller.sv
// Top level of the bus turn poller: round-robin turn master of a shared bus.
//
// Channels: in_ch carries bus events (assign/unassign channel, start, packet
// received, timeout expired, stop); out_ch carries results (turn signal,
// success, end transmission, quit announce, deliver, member quit, cycle done,
// wait), from zero to three per event, the final one flagged by last. Both
// are valid/ready; a transfer happens when valid and ready are both high.
// The cfg_ APB port holds the two 64-bit topic subscription masks at byte
// addresses 0 and 8; writes take effect at the access cycle, pready is tied high.
//
// Timing: one event at a time. An assign, unassign or stop runs no scan;
// an event that moves the turn runs a scan over the channel map memory, one
// 8-channel row per cycle. The single read port of the map memory sets the
// scan speed.
//
// Reset (rst_n, synchronous): the map reads as all clear, the poller is idle
// with turn 0 and both topic masks are zero. The map memory itself is not
// swept; per-row valid bits make unwritten rows read as clear.
//
// Receiver stall: results sit in an output register; the poller holds its
// state until the register frees. in_ch is ready whenever the poller is idle,
// even while the last result of the previous event still waits.
`timescale 1ns / 1ps
`default_nettype none
module bus_turn_poller
  import btp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  btp_stream_if.sink       in_ch,
  btp_stream_if.source     out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW_WR,
    ST_EMIT,
    ST_CONT,
    ST_SCAN
  } state_t;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [63:0] topics_low_r;
  logic [63:0] topics_high_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[3] == REG_TOPICS_HIGH) ? topics_high_r : topics_low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      topics_low_r  <= '0;
      topics_high_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[3] == REG_TOPICS_HIGH) begin
        topics_high_r <= cfg_pwdata;
      end else begin
        topics_low_r <= cfg_pwdata;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Channel map memory
  // ---------------------------------------------------------------------
  btp_map_req_t map_req;
  logic [7:0]   map_rdata;

  btp_map u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (map_req),
    .rdata (map_rdata)
  );

  // ---------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------
  state_t           state_r,     state_nxt;
  logic             running_r,   running_nxt;
  logic [7:0]       turn_r,      turn_nxt;
  logic [ROW_W-1:0] row_r,       row_nxt;      // row under modify or scan
  logic [2:0]       bit_r,       bit_nxt;      // bit to modify, or scan start bit
  logic             set_r,       set_nxt;      // modify sets (assign) or clears
  logic             post_r,      post_nxt;     // after write-back, go emit
  logic             cont_r,      cont_nxt;     // after pending results, move turn
  logic [1:0]       pend_cnt_r,  pend_cnt_nxt;
  logic [2:0]       pend_kind_r [2];
  logic [2:0]       pend_kind_nxt [2];
  logic [7:0]       pend_val_r [2];
  logic [7:0]       pend_val_nxt [2];
  logic             out_valid_r, out_valid_nxt;
  btp_out_t         out_data_r,  out_data_nxt;

  btp_in_t    in_item;
  logic       in_fire;
  logic       out_free;
  logic       subscribed;
  logic [7:0] next_turn;
  logic [7:0] row_mask;
  logic [7:0] row_hits;
  logic       hit_found;
  logic [2:0] hit_bit;
  logic [7:0] bit_onehot;

  assign in_item     = in_ch.data;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Topic 128..191 in the low mask, 192..255 in the high mask
  assign subscribed = in_item.target[6] ? topics_high_r[in_item.target[5:0]]
                                        : topics_low_r[in_item.target[5:0]];

  assign next_turn  = turn_r + 8'd1;
  assign bit_onehot = 8'd1 << bit_r;
  assign row_mask   = 8'hFF << bit_r;
  assign row_hits   = map_rdata & row_mask;

  // Lowest assigned channel at or above the start bit in this row
  always_comb begin
    hit_found = 1'b0;
    hit_bit   = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (row_hits[i]) begin
        hit_found = 1'b1;
        hit_bit   = 3'(i);
      end
    end
  end

  always_comb begin
    state_nxt        = state_r;
    running_nxt      = running_r;
    turn_nxt         = turn_r;
    row_nxt          = row_r;
    bit_nxt          = bit_r;
    set_nxt          = set_r;
    post_nxt         = post_r;
    cont_nxt         = cont_r;
    pend_cnt_nxt     = pend_cnt_r;
    pend_kind_nxt    = pend_kind_r;
    pend_val_nxt     = pend_val_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_data_nxt     = out_data_r;
    map_req          = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          pend_cnt_nxt = 2'd0;
          cont_nxt     = 1'b0;
          post_nxt     = 1'b0;
          case (in_item.mode)
            MODE_ASSIGN, MODE_UNASSIGN: begin
              // Read the row now, write it back next cycle
              map_req.rd = 1'b1;
              map_req.row = in_item.channel[7:3];
              row_nxt    = in_item.channel[7:3];
              bit_nxt    = in_item.channel[2:0];
              set_nxt    = (in_item.mode == MODE_ASSIGN);
              state_nxt  = ST_RMW_WR;
            end
            MODE_START: begin
              if (!running_r) begin
                running_nxt = 1'b1;
                map_req.rd  = 1'b1;
                map_req.row = '0;
                row_nxt     = '0;
                bit_nxt     = 3'd1;  // channel 0 is never polled
                state_nxt   = ST_SCAN;
              end
            end
            MODE_STOP: begin
              running_nxt = 1'b0;
              turn_nxt    = 8'd0;
            end
            MODE_PACKET: begin
              if (running_r) begin
                case (in_item.packet_kind)
                  PKT_TRANSMIT: begin
                    if (in_item.target[7]) begin
                      if (subscribed) begin
                        pend_kind_nxt[0] = KIND_DELIVER;
                        pend_val_nxt[0]  = in_item.source;
                        pend_kind_nxt[1] = KIND_SUCCESS;
                        pend_val_nxt[1]  = 8'd0;
                        pend_cnt_nxt     = 2'd2;
                      end else begin
                        pend_kind_nxt[0] = KIND_SUCCESS;
                        pend_val_nxt[0]  = 8'd0;
                        pend_cnt_nxt     = 2'd1;
                      end
                      cont_nxt = 1'b1;
                    end else if (in_item.target == 8'd0) begin
                      pend_kind_nxt[0] = KIND_DELIVER;
                      pend_val_nxt[0]  = in_item.source;
                      pend_kind_nxt[1] = KIND_SUCCESS;
                      pend_val_nxt[1]  = 8'd0;
                      pend_cnt_nxt     = 2'd2;
                      cont_nxt         = 1'b1;
                    end else begin
                      // Peer-to-peer transmit: turn stays put
                      pend_kind_nxt[0] = KIND_WAIT;
                      pend_val_nxt[0]  = 8'd0;
                      pend_cnt_nxt     = 2'd1;
                    end
                    state_nxt = ST_EMIT;
                  end
                  PKT_OTHER: begin
                    pend_kind_nxt[0] = KIND_END_TX;
                    pend_val_nxt[0]  = 8'd0;
                    pend_cnt_nxt     = 2'd1;
                    cont_nxt         = 1'b1;
                    state_nxt        = ST_EMIT;
                  end
                  default: begin
                    state_nxt = ST_CONT;
                  end
                endcase
              end
            end
            MODE_TIMEOUT: begin
              if (running_r) begin
                cont_nxt = 1'b1;
                if (!turn_r[7]) begin
                  // Silent peer: drop it from the map and announce the quit
                  pend_kind_nxt[0] = KIND_QUIT_ANN;
                  pend_val_nxt[0]  = turn_r;
                  pend_kind_nxt[1] = KIND_MEMBER_QUIT;
                  pend_val_nxt[1]  = turn_r;
                  pend_cnt_nxt     = 2'd2;
                  map_req.rd       = 1'b1;
                  map_req.row      = turn_r[7:3];
                  row_nxt          = turn_r[7:3];
                  bit_nxt          = turn_r[2:0];
                  set_nxt          = 1'b0;
                  post_nxt         = 1'b1;
                  state_nxt        = ST_RMW_WR;
                end else begin
                  state_nxt = ST_CONT;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_RMW_WR: begin
        map_req.wr    = 1'b1;
        map_req.row   = row_r;
        map_req.wdata = set_r ? (map_rdata | bit_onehot) : (map_rdata & ~bit_onehot);
        state_nxt     = post_r ? ST_EMIT : ST_IDLE;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.kind        = pend_kind_r[0];
          out_data_nxt.value       = pend_val_r[0];
          out_data_nxt.arm_timeout = (pend_kind_r[0] == KIND_WAIT);
          out_data_nxt.last        = (pend_cnt_r == 2'd1) && !cont_r;
          pend_kind_nxt[0]         = pend_kind_r[1];
          pend_val_nxt[0]          = pend_val_r[1];
          pend_cnt_nxt             = pend_cnt_r - 2'd1;
          if (pend_cnt_r == 2'd1) begin
            state_nxt = cont_r ? ST_CONT : ST_IDLE;
          end
        end
      end

      ST_CONT: begin
        if (turn_r == LAST_CHANNEL) begin
          // Wrapped past the last topic: cycle is over
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{kind: KIND_CYCLE_DONE, value: 8'd0,
                              arm_timeout: 1'b0, last: 1'b1};
            running_nxt   = 1'b0;
            turn_nxt      = 8'd0;
            state_nxt     = ST_IDLE;
          end
        end else begin
          map_req.rd  = 1'b1;
          map_req.row = next_turn[7:3];
          row_nxt     = next_turn[7:3];
          bit_nxt     = next_turn[2:0];
          state_nxt   = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (hit_found) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{kind: KIND_TURN, value: {row_r, hit_bit},
                              arm_timeout: 1'b1, last: 1'b1};
            turn_nxt      = {row_r, hit_bit};
            state_nxt     = ST_IDLE;
          end
        end else if (row_r == LAST_ROW) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{kind: KIND_CYCLE_DONE, value: 8'd0,
                              arm_timeout: 1'b0, last: 1'b1};
            running_nxt   = 1'b0;
            turn_nxt      = 8'd0;
            state_nxt     = ST_IDLE;
          end
        end else begin
          // Advance one row; data lands next cycle
          map_req.rd  = 1'b1;
          map_req.row = row_r + 1'b1;
          row_nxt     = row_r + 1'b1;
          bit_nxt     = 3'd0;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      running_r   <= 1'b0;
      turn_r      <= 8'd0;
      pend_cnt_r  <= 2'd0;
      cont_r      <= 1'b0;
      post_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      turn_r      <= turn_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      cont_r      <= cont_nxt;
      post_r      <= post_nxt;
      out_valid_r <= out_valid_nxt;
    end
    row_r       <= row_nxt;
    bit_r       <= bit_nxt;
    set_r       <= set_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_val_r  <= pend_val_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule
`default_nettype wire

### hdl/btp_checker.sv
// Port-level checker for the bus turn poller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module btp_checker
  import btp_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire btp_out_t out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A turn arms the timeout and closes its event
  a_turn_arm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_TURN |-> out_data.arm_timeout && out_data.last)
    else $error("turn signal without timeout arm or last");

  // Cycle done closes its event and carries no channel
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_CYCLE_DONE |->
      out_data.last && out_data.value == 8'd0 && !out_data.arm_timeout)
    else $error("malformed cycle done");

  // Wait ends the event and arms the timeout
  a_wait_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_WAIT |-> out_data.last && out_data.arm_timeout)
    else $error("malformed wait");

endmodule

bind bus_turn_poller btp_checker u_btp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
`default_nettype wire

### tb/btp_turn_checker.sv
// Result checker of the bus turn poller: predicts results per bus event and compares them.
`timescale 1ns / 1ps
module btp_turn_checker
  import btp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        ev_valid,
  input  logic        ev_ready,
  input  btp_in_t     ev_data,
  input  logic        res_valid,
  input  logic        res_ready,
  input  btp_out_t    res_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output int          fail_count,
  output int          results_owed,
  output int          events_seen
);

  localparam logic [7:0] BROADCAST_BIT    = 8'h80;
  localparam logic [7:0] TOPIC_BASE       = 8'd128;
  localparam logic [7:0] TOPIC_UPPER_BASE = 8'd192;
  localparam int         MAX_REPORTS      = 10;

  logic [255:0] chan_map;
  logic [7:0]   turn_at;
  logic         polling;
  logic [63:0]  topics_lo;
  logic [63:0]  topics_hi;
  btp_out_t     owed_results[$];
  btp_out_t     burst[3];
  int           n_burst;
  int           n_fail;
  int           n_events;

  function automatic void emit_result(input logic [2:0] kind, input logic [7:0] value,
                                      input logic arm);
    burst[n_burst] = btp_out_t'{kind: kind, value: value, arm_timeout: arm, last: 1'b0};
    n_burst++;
  endfunction

  // Walk upward to the next marked channel; none left ends the cycle.
  function automatic void scan_from(input int first);
    for (int c = first; c < 256; c++) begin
      if (chan_map[c]) begin
        turn_at = 8'(c);
        emit_result(KIND_TURN, 8'(c), 1'b1);
        return;
      end
    end
    turn_at = '0;
    polling = 1'b0;
    emit_result(KIND_CYCLE_DONE, '0, 1'b0);
  endfunction

  function automatic void advance_turn();
    if (turn_at == LAST_CHANNEL) begin
      turn_at = '0;
      polling = 1'b0;
      emit_result(KIND_CYCLE_DONE, '0, 1'b0);
    end else begin
      scan_from(int'(turn_at) + 1);
    end
  endfunction

  function automatic logic subscribed(input logic [7:0] topic);
    if (topic >= TOPIC_UPPER_BASE)
      return topics_hi[topic - TOPIC_UPPER_BASE];
    return topics_lo[topic - TOPIC_BASE];
  endfunction

  function automatic void play_bus_event(input btp_in_t ev);
    n_burst = 0;
    case (ev.mode)
      MODE_ASSIGN:   chan_map[ev.channel] = 1'b1;
      MODE_UNASSIGN: chan_map[ev.channel] = 1'b0;
      MODE_START: if (!polling) begin
        polling = 1'b1;
        scan_from(1);
      end
      MODE_STOP: begin
        polling = 1'b0;
        turn_at = '0;
      end
      MODE_PACKET: if (polling) begin
        if (ev.packet_kind == PKT_TRANSMIT) begin
          if ((ev.target & BROADCAST_BIT) != '0) begin
            if (subscribed(ev.target))
              emit_result(KIND_DELIVER, ev.source, 1'b0);
            emit_result(KIND_SUCCESS, '0, 1'b0);
            advance_turn();
          end else if (ev.target == '0) begin
            emit_result(KIND_DELIVER, ev.source, 1'b0);
            emit_result(KIND_SUCCESS, '0, 1'b0);
            advance_turn();
          end else begin
            emit_result(KIND_WAIT, '0, 1'b1);
          end
        end else if (ev.packet_kind == PKT_OTHER) begin
          emit_result(KIND_END_TX, '0, 1'b0);
          advance_turn();
        end else begin
          advance_turn();
        end
      end
      MODE_TIMEOUT: if (polling) begin
        // peer turns lose their slot; topic turns just move on
        if (turn_at < TOPIC_BASE) begin
          chan_map[turn_at] = 1'b0;
          emit_result(KIND_QUIT_ANN, turn_at, 1'b0);
          emit_result(KIND_MEMBER_QUIT, turn_at, 1'b0);
        end
        advance_turn();
      end
      default: ;
    endcase
    if (n_burst > 0)
      burst[n_burst - 1].last = 1'b1;
    for (int i = 0; i < n_burst; i++)
      owed_results.push_back(burst[i]);
    n_events++;
  endfunction

  always @(posedge clk) begin
    btp_out_t want;
    if (!rst_n) begin
      chan_map  = '0;
      turn_at   = '0;
      polling   = 1'b0;
      topics_lo = '0;
      topics_hi = '0;
      owed_results.delete();
      n_fail    = 0;
      n_events  = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[3] == REG_TOPICS_LOW)
          topics_lo = cfg_pwdata;
        else
          topics_hi = cfg_pwdata;
      end
      if (ev_valid && ev_ready)
        play_bus_event(ev_data);
      if (res_valid && res_ready) begin
        if (owed_results.size() == 0) begin
          if (n_fail < MAX_REPORTS)
            $display("%0t: unexpected result kind %0d value %0d arm %0d last %0d", $realtime,
                     res_data.kind, res_data.value, res_data.arm_timeout, res_data.last);
          n_fail++;
        end else begin
          want = owed_results.pop_front();
          if (res_data.kind !== want.kind || res_data.value !== want.value ||
              res_data.arm_timeout !== want.arm_timeout || res_data.last !== want.last) begin
            if (n_fail < MAX_REPORTS)
              $display("%0t: result mismatch: expected kind %0d value %0d arm %0d last %0d, %s",
                       $realtime, want.kind, want.value, want.arm_timeout, want.last,
                       $sformatf("got kind %0d value %0d arm %0d last %0d", res_data.kind,
                                 res_data.value, res_data.arm_timeout, res_data.last));
            n_fail++;
          end
        end
      end
    end
    fail_count   <= n_fail;
    results_owed <= owed_results.size();
    events_seen  <= n_events;
  end

endmodule

### tb/tb_bus_turn_poller.sv
// Testbench top of the bus turn poller: stimulus, idling, register writes and verdict.
`timescale 1ns / 1ps
module tb_bus_turn_poller;
  import btp_pkg::*;

  // Modes the block must ignore
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam int PHASES        = 6;
  localparam int PHASE_EVENTS  = 30;   // with the directed part, about 210 events in all
  localparam int SETTLE_CYCLES = 50;   // longest scan plus margin
  localparam int TAIL_CYCLES   = 60;
  localparam int QUIET_LIMIT   = 2000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          results_owed;
  int          events_seen;
  int          gap_pct = 10;     // chance in percent that either side starts an idle burst
  int          quiet_cycles = 0;

  btp_stream_if #(.T(btp_in_t))  in_ch();
  btp_stream_if #(.T(btp_out_t)) out_ch();

  always #5 clk = ~clk;

  bus_turn_poller DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  btp_turn_checker turn_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .ev_valid    (in_ch.valid),
    .ev_ready    (in_ch.ready),
    .ev_data     (in_ch.data),
    .res_valid   (out_ch.valid),
    .res_ready   (out_ch.ready),
    .res_data    (out_ch.data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .fail_count  (fail_count),
    .results_owed(results_owed),
    .events_seen (events_seen)
  );

  // Setup cycle, access cycle, then a return to idle so that back-to-back writes
  // never drive psel twice in the same step.
  task automatic write_topics(input logic idx, input logic [63:0] mask);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= mask;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one bus event, maybe after an idle burst, and hold it until the transfer.
  // Valid stays high on return so the next event can follow back to back.
  task automatic push_event(input btp_in_t ev);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= ev;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and hold until every owed result has arrived, then let any
  // result-free event finish before the registers are touched.
  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly bus traffic that keeps a poll cycle alive, with map edits, restarts,
  // stops and ignored modes mixed in.
  function automatic btp_in_t rand_bus_event();
    btp_in_t ev;
    int      pick;
    ev.mode        = MODE_PACKET;
    ev.channel     = 8'($urandom);
    ev.packet_kind = 2'($urandom);
    ev.target      = 8'($urandom);
    ev.source      = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 14) begin
      ev.mode = MODE_ASSIGN;
    end else if (pick < 20) begin
      ev.mode = MODE_UNASSIGN;
    end else if (pick < 28) begin
      ev.mode = MODE_START;
    end else if (pick < 30) begin
      ev.mode = MODE_STOP;
    end else if (pick < 32) begin
      ev.mode = ($urandom_range(0, 1) == 0) ? MODE_SPARE_LO : MODE_SPARE_HI;
    end else if (pick < 72) begin
      // favor transmits aimed at the leader or at a topic
      if ($urandom_range(0, 1) == 0)
        ev.packet_kind = PKT_TRANSMIT;
      pick = $urandom_range(0, 9);
      if (pick < 3)
        ev.target = '0;
      else if (pick < 7)
        ev.target = 8'($urandom_range(128, 255));
    end else begin
      ev.mode = MODE_TIMEOUT;
    end
    return ev;
  endfunction

  // Result side: random stall bursts while gaps are enabled.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // End the run if nothing moves on any port for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          goal;
    logic [63:0] lo_mask;
    logic [63:0] hi_mask;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    rst_n       <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: subscribe to the first and the last topic only.
    write_topics(REG_TOPICS_LOW, 64'h0000_0000_0000_0001);
    write_topics(REG_TOPICS_HIGH, 64'h8000_0000_0000_0000);

    // bus events while idle and unused modes: all ignored
    push_event(btp_in_t'{MODE_PACKET, 8'h00, PKT_TRANSMIT, 8'h00, 8'h00});
    push_event(btp_in_t'{MODE_TIMEOUT, 8'h00, PKT_TRANSMIT, 8'h00, 8'h00});
    push_event(btp_in_t'{MODE_SPARE_LO, 8'hFF, PKT_OTHER, 8'hFF, 8'hFF});
    push_event(btp_in_t'{MODE_SPARE_HI, 8'h00, PKT_TRANSMIT, 8'h00, 8'h00});
    // start on an empty map: the cycle ends at once
    push_event(btp_in_t'{MODE_START, 8'h00, PKT_TRANSMIT, 8'h00, 8'h00});
    // mark channel 0 (never polled) and the edges of both channel ranges
    push_event(btp_in_t'{MODE_ASSIGN, 8'd0, PKT_TRANSMIT, 8'h00, 8'h00});
    push_event(btp_in_t'{MODE_ASSIGN, 8'd1, PKT_TRANSMIT, 8'h00, 8'h00});
    push_event(btp_in_t'{MODE_ASSIGN, 8'd127, PKT_TRANSMIT, 8'h00, 8'h00});
    push_event(btp_in_t'{MODE_ASSIGN, 8'd128, PKT_TRANSMIT, 8'h00, 8'h00});
    push_event(btp_in_t'{MODE_ASSIGN, 8'd255, PKT_TRANSMIT, 8'h00, 8'h00});
    // start polls channel 1; a second start is ignored
    push_event(btp_in_t'{MODE_START, 8'h00, PKT_TRANSMIT, 8'h00, 8'h00});
    push_event(btp_in_t'{MODE_START, 8'hFF, PKT_OTHER, 8'hFF, 8'hFF});
    // transmit to the leader, then to another peer (turn held)
    push_event(btp_in_t'{MODE_PACKET, 8'h00, PKT_TRANSMIT, 8'h00, 8'hFF});
    push_event(btp_in_t'{MODE_PACKET, 8'h00, PKT_TRANSMIT, 8'h7F, 8'h55});
    // peer timeout on 127: quit announced, scan reaches the first topic
    push_event(btp_in_t'{MODE_TIMEOUT, 8'h00, PKT_TRANSMIT, 8'h00, 8'h00});
    // a channel marked ahead of the turn is picked up by the scan
    push_event(btp_in_t'{MODE_ASSIGN, 8'd200, PKT_TRANSMIT, 8'h00, 8'h00});
    push_event(btp_in_t'{MODE_PACKET, 8'h00, PKT_TRANSMIT, 8'h81, 8'h00});
    push_event(btp_in_t'{MODE_PACKET, 8'h00, PKT_OTHER, 8'h00, 8'h00});
    // subscribed last topic on channel 255, then wrap ends the cycle
    push_event(btp_in_t'{MODE_PACKET, 8'h00, PKT_TRANSMIT, 8'hFF, 8'hAA});
    push_event(btp_in_t'{MODE_START, 8'h00, PKT_TRANSMIT, 8'h00, 8'h00});
    // timeout on a peer whose bit was already cleared still announces the quit
    push_event(btp_in_t'{MODE_UNASSIGN, 8'd1, PKT_TRANSMIT, 8'h00, 8'h00});
    push_event(btp_in_t'{MODE_TIMEOUT, 8'h00, PKT_TRANSMIT, 8'h00, 8'h00});
    push_event(btp_in_t'{MODE_PACKET, 8'h00, PKT_SUCCESS, 8'h00, 8'h00});
    // timeout on a topic turn only advances
    push_event(btp_in_t'{MODE_TIMEOUT, 8'h00, PKT_TRANSMIT, 8'h00, 8'h00});
    push_event(btp_in_t'{MODE_PACKET, 8'h00, PKT_FAIL, 8'h00, 8'h00});
    // subscribed first topic, then stop and a packet that is ignored
    push_event(btp_in_t'{MODE_START, 8'h00, PKT_TRANSMIT, 8'h00, 8'h00});
    push_event(btp_in_t'{MODE_PACKET, 8'h00, PKT_TRANSMIT, 8'h80, 8'h01});
    push_event(btp_in_t'{MODE_STOP, 8'h00, PKT_TRANSMIT, 8'h00, 8'h00});
    push_event(btp_in_t'{MODE_PACKET, 8'h00, PKT_TRANSMIT, 8'h00, 8'h01});

    // Random part, one topic setting and idle rate per phase.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_and_settle();
      case (ph)
        0: begin
          lo_mask = '1;
          hi_mask = '1;
          gap_pct = 15;
        end
        1: begin
          lo_mask = '0;
          hi_mask = '0;
          gap_pct = 30;
        end
        2: begin
          lo_mask = 64'hAAAA_AAAA_AAAA_AAAA;
          hi_mask = 64'h5555_5555_5555_5555;
          gap_pct = 5;
        end
        3: begin
          lo_mask = {$urandom, $urandom};
          hi_mask = {$urandom, $urandom};
          gap_pct = 20;
        end
        4: begin
          lo_mask = {$urandom, $urandom};
          hi_mask = '1;
          gap_pct = 35;
        end
        default: begin
          // last stretch runs with no idling on either side
          lo_mask = 64'h8000_0000_0000_0001;
          hi_mask = {$urandom, $urandom};
          gap_pct = 0;
        end
      endcase
      write_topics(REG_TOPICS_LOW, lo_mask);
      write_topics(REG_TOPICS_HIGH, hi_mask);
      goal = events_seen + PHASE_EVENTS;
      while (events_seen < goal) push_event(rand_bus_event());
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
